// File: rtl/apfs_pkg.sv
// Package for the aged priority frame selector.
// Holds the field widths, slot numbering, register indexes and reset values.
// No dependencies; compile this file first.
package apfs_pkg;

  localparam int NUM_SLOTS   = 12;
  localparam int ID_BITS_DEF = 16;
  localparam int SLOT_W      = 4;
  localparam int ID_W        = 16;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int REQ_W       = 2;

  // Slot numbering: six fixed-priority slots, four aged slots, then the tail.
  localparam int AGED_FIRST   = 6;
  localparam int AGED_COUNT   = 4;
  localparam int AGED_IDX_W   = 2;
  localparam int SLOT_STATUS  = 9;
  localparam int SLOT_XSTATUS = 10;
  localparam int SLOT_OTHER   = 11;
  localparam int AGED_STATUS  = SLOT_STATUS - AGED_FIRST;

  // The cap is 100 times a 16-bit memory time, which fits in 23 bits; a score
  // is at most the cap plus a 16-bit bias, which fits in 24 bits.
  localparam int CAP_FACTOR = 100;
  localparam int CAP_W      = 23;
  localparam int SCORE_W    = 24;

  typedef enum logic [REQ_W-1:0] {
    REQ_STORE = 2'd0,
    REQ_DATA  = 2'd1,
    REQ_TICK  = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEMORY_TIME  = 3'd0,
    CFG_TRACK_BIAS   = 3'd1,
    CFG_CONTACT_BIAS = 3'd2,
    CFG_NOISE_BIAS   = 3'd3,
    CFG_STATUS_BIAS  = 3'd4
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] MEMORY_TIME_RST  = 16'd960;
  localparam logic [CFG_W-1:0] TRACK_BIAS_RST   = 16'd1331;
  localparam logic [CFG_W-1:0] CONTACT_BIAS_RST = 16'd665;
  localparam logic [CFG_W-1:0] NOISE_BIAS_RST   = 16'd323;
  localparam logic [CFG_W-1:0] STATUS_BIAS_RST  = 16'd0;

endpackage

// File: rtl/apfs_in_if.sv
// Input channel of the aged priority frame selector: one word per store,
// request or tick. Depends on apfs_pkg for the field widths.
interface apfs_in_if;
  import apfs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [SLOT_W-1:0]    frame_type;
  logic [ID_W-1:0]      frame_id;
  logic                 ack_flag;
  logic [TIME_W-1:0]    now_time;

  modport source (output valid, req_type, frame_type, frame_id, ack_flag, now_time,
                  input ready);
  modport sink   (input valid, req_type, frame_type, frame_id, ack_flag, now_time,
                  output ready);
endinterface

// File: rtl/apfs_out_if.sv
// Result channel of the aged priority frame selector: one word per request.
// Depends on apfs_pkg for the field widths.
interface apfs_out_if;
  import apfs_pkg::*;

  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   sent_id;
  logic              sent_valid;
  logic [SLOT_W-1:0] sent_kind;

  modport source (output valid, sent_id, sent_valid, sent_kind, input ready);
  modport sink   (input valid, sent_id, sent_valid, sent_kind, output ready);
endinterface

// File: rtl/apfs_cfg_if.sv
// Configuration write channel of the aged priority frame selector.
// Depends on apfs_pkg for the index and data widths.
interface apfs_cfg_if;
  import apfs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/aged_priority_frame_selector.sv
// Aged priority frame selector, top level; needs apfs_pkg and the three channel interfaces.
// A request word's result passes through the input register, then the result
// register. Throughput: one word per cycle while no request waits on a full result
// register, set by the combinational priority chain and four-way score compare.
// Reset (rst_n low, synchronous) empties all slots, clears marks and scores,
// and loads the default weights; slot contents are left as they were.
module aged_priority_frame_selector #(
  parameter int ID_BITS = apfs_pkg::ID_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  apfs_in_if.sink    in_ch,
  apfs_out_if.source out_ch,
  apfs_cfg_if.sink   cfg_ch
);
  import apfs_pkg::*;

  // Bits of a handle that are kept in a slot.
  localparam int KEEP_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;

  // Configuration registers.
  logic [CFG_W-1:0]   mem_time_r;
  logic [CFG_W-1:0]   bias_r [AGED_COUNT];

  // Input register.
  logic               s1_valid_r;
  req_t               s1_req_r;
  logic [SLOT_W-1:0]  s1_type_r;
  logic [ID_W-1:0]    s1_id_r;
  logic               s1_ack_r;
  logic [TIME_W-1:0]  s1_now_r;

  // Slot and aging state.
  logic [NUM_SLOTS-1:0] slot_full_r;
  logic [KEEP_W-1:0]    slot_frame_r [NUM_SLOTS];
  logic [TIME_W-1:0]    mark_r [AGED_COUNT];
  logic [SCORE_W-1:0]   score_r [AGED_COUNT];

  // Result register.
  logic               out_valid_r;
  logic [ID_W-1:0]    out_id_r;
  logic               out_sent_r;
  logic [SLOT_W-1:0]  out_kind_r;

  logic               in_accept;
  logic               s1_is_data;
  logic               s1_go;
  logic [CAP_W-1:0]   cap;
  logic [TIME_W-1:0]  age [AGED_COUNT];
  logic [SCORE_W-1:0] tick_score [AGED_COUNT];
  logic [SLOT_W-1:0]  store_slot;

  logic               ack_hit;
  logic               fixed_hit;
  logic [SLOT_W-1:0]  fixed_slot;
  logic               aged_hit;
  logic [AGED_IDX_W-1:0] aged_k;
  logic [SCORE_W-1:0] aged_best;
  logic               pick_valid;
  logic               pick_aged;
  logic [SLOT_W-1:0]  pick_slot;
  logic [KEEP_W-1:0]  pick_frame;

  assign s1_is_data = (s1_req_r == REQ_DATA);
  // A request may only leave the input register when the result register
  // is free or being emptied; store and tick words never wait.
  assign s1_go      = s1_valid_r && (!s1_is_data || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_accept  = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign cap = CAP_W'(mem_time_r) * CAP_W'(CAP_FACTOR);

  always_comb begin
    for (int k = 0; k < AGED_COUNT; k++) begin
      age[k] = s1_now_r - mark_r[k];
      // The wrapping difference means a mark in the future also saturates.
      if (age[k] <= TIME_W'(cap)) begin
        tick_score[k] = SCORE_W'(age[k][CAP_W-1:0]) + SCORE_W'(bias_r[k]);
      end else begin
        tick_score[k] = SCORE_W'(cap);
      end
    end
  end

  assign store_slot = (s1_type_r < SLOT_W'(NUM_SLOTS)) ? s1_type_r : SLOT_W'(SLOT_OTHER);

  // Priority selection for a request.
  always_comb begin
    ack_hit    = s1_ack_r && slot_full_r[SLOT_STATUS];

    fixed_hit  = 1'b0;
    fixed_slot = '0;
    for (int s = AGED_FIRST - 1; s >= 0; s--) begin
      if (slot_full_r[s]) begin
        fixed_hit  = 1'b1;
        fixed_slot = SLOT_W'(s);
      end
    end

    // Walk from status down to track; a later entry wins only on a strictly
    // higher score, so ties favour status, then noise, then contact.
    aged_hit  = 1'b0;
    aged_k    = '0;
    aged_best = '0;
    for (int k = AGED_COUNT - 1; k >= 0; k--) begin
      if (slot_full_r[AGED_FIRST + k] && (!aged_hit || score_r[k] > aged_best)) begin
        aged_hit  = 1'b1;
        aged_k    = AGED_IDX_W'(k);
        aged_best = score_r[k];
      end
    end

    pick_valid = 1'b1;
    pick_aged  = 1'b0;
    if (ack_hit) begin
      pick_slot = SLOT_W'(SLOT_STATUS);
    end else if (fixed_hit) begin
      pick_slot = fixed_slot;
    end else if (aged_hit) begin
      pick_slot = SLOT_W'(AGED_FIRST) + SLOT_W'(aged_k);
      pick_aged = 1'b1;
    end else if (slot_full_r[SLOT_XSTATUS]) begin
      pick_slot = SLOT_W'(SLOT_XSTATUS);
    end else if (slot_full_r[SLOT_OTHER]) begin
      pick_slot = SLOT_W'(SLOT_OTHER);
    end else begin
      pick_slot  = '0;
      pick_valid = 1'b0;
    end
    pick_frame = slot_frame_r[pick_slot];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_time_r <= MEMORY_TIME_RST;
      bias_r[0]  <= TRACK_BIAS_RST;
      bias_r[1]  <= CONTACT_BIAS_RST;
      bias_r[2]  <= NOISE_BIAS_RST;
      bias_r[3]  <= STATUS_BIAS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        CFG_MEMORY_TIME:  mem_time_r <= cfg_ch.data;
        CFG_TRACK_BIAS:   bias_r[0]  <= cfg_ch.data;
        CFG_CONTACT_BIAS: bias_r[1]  <= cfg_ch.data;
        CFG_NOISE_BIAS:   bias_r[2]  <= cfg_ch.data;
        CFG_STATUS_BIAS:  bias_r[3]  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r  <= req_t'(in_ch.req_type);
      s1_type_r <= in_ch.frame_type;
      s1_id_r   <= in_ch.frame_id;
      s1_ack_r  <= in_ch.ack_flag;
      s1_now_r  <= in_ch.now_time;
    end
  end

  // Slot contents have no reset: a slot is read only once it is full.
  always_ff @(posedge clk) begin
    if (s1_go && s1_req_r == REQ_STORE) begin
      slot_frame_r[store_slot] <= s1_id_r[KEEP_W-1:0];
    end
  end

  // Occupancy, marks and scores.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_full_r <= '0;
      for (int k = 0; k < AGED_COUNT; k++) begin
        mark_r[k]  <= '0;
        score_r[k] <= '0;
      end
    end else if (s1_go) begin
      case (s1_req_r)
        REQ_STORE: begin
          slot_full_r[store_slot] <= 1'b1;
        end
        REQ_DATA: begin
          if (ack_hit) begin
            // Acknowledged status is sent but kept, and pushed to the cap.
            score_r[AGED_STATUS] <= SCORE_W'(cap);
            mark_r[AGED_STATUS]  <= s1_now_r;
          end else if (pick_valid) begin
            slot_full_r[pick_slot] <= 1'b0;
            if (pick_aged) begin
              mark_r[aged_k] <= s1_now_r;
            end
          end
        end
        REQ_TICK: begin
          for (int k = 0; k < AGED_COUNT; k++) begin
            score_r[k] <= tick_score[k];
          end
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_is_data) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_is_data) begin
      out_id_r   <= pick_valid ? ID_W'(pick_frame) : '0;
      out_sent_r <= pick_valid;
      out_kind_r <= pick_slot;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sent_id    = out_id_r;
  assign out_ch.sent_valid = out_sent_r;
  assign out_ch.sent_kind  = out_kind_r;

endmodule
